// File: hw/rtl/mrsi_pkg.sv
// Shared constants and types of the mixed-radix state index codec.
// Used by mrsi_cell and mixed_radix_state_index_codec_top; no dependencies.
package mrsi_pkg;

  localparam int IDX_W        = 64;  // width of the packed index
  localparam int ROBOTS       = 4;   // robots in one planning state
  localparam int NDIG         = 2 * ROBOTS;  // positions, then waypoint indices
  localparam int POS_BITS_DEF = 16;
  localparam int WP_BITS_DEF  = 8;
  localparam int DIV_BITS     = 4;   // quotient bits resolved per divider step
  localparam int NSUB         = IDX_W / DIV_BITS;  // steps per digit cell
  localparam int ADDR_W       = 5;
  localparam int REG_IDX_W    = 3;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_VERTEX = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WP0    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WP1    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WP2    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WP3    = 3'd4;

  typedef struct packed {
    logic valid;
    logic func;
    logic ovf;
  } ctl_t;

endpackage

// File: hw/rtl/mrsi_cell.sv
// One digit cell of the codec chain: Horner multiply-add on encode,
// pipelined restoring division on decode. Depends on mrsi_pkg.
module mrsi_cell #(
  parameter int DW       = mrsi_pkg::POS_BITS_DEF,
  parameter int ENC_SLOT = 0,
  parameter int DEC_SLOT = mrsi_pkg::NDIG - 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [DW-1:0]                  radix_enc,
  input  logic [DW-1:0]                  radix_dec,
  input  mrsi_pkg::ctl_t                 ctl_in,
  input  logic [mrsi_pkg::IDX_W-1:0]     acc_in,
  input  logic [mrsi_pkg::NDIG*DW-1:0]   dig_in,
  output mrsi_pkg::ctl_t                 ctl_out,
  output logic [mrsi_pkg::IDX_W-1:0]     acc_out,
  output logic [mrsi_pkg::NDIG*DW-1:0]   dig_out
);

  localparam int NS = mrsi_pkg::NSUB;
  localparam int AW = mrsi_pkg::IDX_W;
  localparam int GW = mrsi_pkg::NDIG * DW;

  mrsi_pkg::ctl_t  ctl_r [NS];
  logic [AW-1:0]   acc_r [NS];
  logic [DW-1:0]   rem_r [NS];
  logic [GW-1:0]   dig_r [NS];

  for (genvar j = 0; j < NS; j++) begin : g_step
    mrsi_pkg::ctl_t ctl_p, ctl_nxt;
    logic [AW-1:0]  acc_p, acc_nxt;
    logic [DW-1:0]  rem_p, rem_nxt;
    logic [GW-1:0]  dig_p, dig_nxt;
    logic [AW+DW-1:0] prod;
    logic [AW:0]      sum;
    logic [DW:0]      trial;

    if (j == 0) begin : g_head
      assign ctl_p = ctl_in;
      assign acc_p = acc_in;
      assign rem_p = '0;
      assign dig_p = dig_in;
    end else begin : g_link
      assign ctl_p = ctl_r[j-1];
      assign acc_p = acc_r[j-1];
      assign rem_p = rem_r[j-1];
      assign dig_p = dig_r[j-1];
    end

    always_comb begin
      ctl_nxt = ctl_p;
      acc_nxt = acc_p;
      rem_nxt = rem_p;
      dig_nxt = dig_p;
      prod    = acc_p * {{AW{1'b0}}, radix_enc};
      sum     = {1'b0, acc_p} + {{(AW+1-DW){1'b0}}, dig_p[ENC_SLOT*DW +: DW]};
      trial   = '0;
      if (ctl_p.func == mrsi_pkg::FUNC_DECODE) begin
        // shift in one dividend bit at a time, MSB first
        for (int b = 0; b < mrsi_pkg::DIV_BITS; b++) begin
          trial   = {rem_nxt, acc_nxt[AW-1]};
          acc_nxt = {acc_nxt[AW-2:0], 1'b0};
          if (trial >= {1'b0, radix_dec}) begin
            trial      = trial - {1'b0, radix_dec};
            acc_nxt[0] = 1'b1;
          end
          rem_nxt = trial[DW-1:0];
        end
        if (j == NS - 1) begin
          dig_nxt[DEC_SLOT*DW +: DW] = rem_nxt;
          rem_nxt = '0;
        end
      end else if (j == 0) begin
        acc_nxt     = prod[AW-1:0];
        ctl_nxt.ovf = ctl_p.ovf | (|prod[AW+DW-1:AW]);
      end else if (j == 1) begin
        acc_nxt     = sum[AW-1:0];
        ctl_nxt.ovf = ctl_p.ovf | sum[AW];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j] <= '0;
      end else begin
        ctl_r[j] <= ctl_nxt;
      end
      acc_r[j] <= acc_nxt;
      rem_r[j] <= rem_nxt;
      dig_r[j] <= dig_nxt;
    end
  end

  assign ctl_out = ctl_r[NS-1];
  assign acc_out = acc_r[NS-1];
  assign dig_out = dig_r[NS-1];

endmodule

// File: hw/rtl/mixed_radix_state_index_codec_top.sv
// Mixed-radix state index codec, top level: register file, digit cell chain
// and result register. Depends on mrsi_pkg and mrsi_cell.
//
// Usage: configure vertex_count (byte address 0) and waypoint_count_0..3
// (addresses 4..16) over the APB-style port while the block is idle; every
// register resets to 1 and a value of 0 acts as radix 1.
// Pulse start with in_func and the payload: func 0 encodes the four
// positions and four waypoint indices into out_index_out (with
// out_overflow on any 64-bit wrap), func 1 decodes in_state_index into
// out_pos_out_* and out_wp_out_*. busy stays low: a transaction is taken
// every cycle.
// Each result shows on the out_ ports for one cycle with out_valid high,
// after 8 digit cells of 16 steps each and the result register, in the
// order the transactions came in. The receiver cannot stall the block.
// Throughput is one transaction per cycle; the chain depth is set by the
// 64-bit division, resolved four quotient bits per step in each digit
// cell. A synchronous reset empties the chain and drops any work.
module mixed_radix_state_index_codec_top #(
  parameter int POS_BITS = mrsi_pkg::POS_BITS_DEF,
  parameter int WP_BITS  = mrsi_pkg::WP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_func,
  input  logic [mrsi_pkg::IDX_W-1:0]        in_state_index,
  input  logic [POS_BITS-1:0]               in_pos_in_0,
  input  logic [POS_BITS-1:0]               in_pos_in_1,
  input  logic [POS_BITS-1:0]               in_pos_in_2,
  input  logic [POS_BITS-1:0]               in_pos_in_3,
  input  logic [WP_BITS-1:0]                in_wp_in_0,
  input  logic [WP_BITS-1:0]                in_wp_in_1,
  input  logic [WP_BITS-1:0]                in_wp_in_2,
  input  logic [WP_BITS-1:0]                in_wp_in_3,
  output logic                              out_valid,
  output logic [mrsi_pkg::IDX_W-1:0]        out_index_out,
  output logic                              out_overflow,
  output logic [POS_BITS-1:0]               out_pos_out_0,
  output logic [POS_BITS-1:0]               out_pos_out_1,
  output logic [POS_BITS-1:0]               out_pos_out_2,
  output logic [POS_BITS-1:0]               out_pos_out_3,
  output logic [WP_BITS-1:0]                out_wp_out_0,
  output logic [WP_BITS-1:0]                out_wp_out_1,
  output logic [WP_BITS-1:0]                out_wp_out_2,
  output logic [WP_BITS-1:0]                out_wp_out_3,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mrsi_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int DW   = (POS_BITS > WP_BITS) ? POS_BITS : WP_BITS;
  localparam int ND   = mrsi_pkg::NDIG;
  localparam int RB   = mrsi_pkg::ROBOTS;
  localparam int AW   = mrsi_pkg::IDX_W;
  localparam int GW   = ND * DW;
  localparam int LAT  = ND * mrsi_pkg::NSUB + 1;

  // configuration registers
  logic [POS_BITS-1:0] vertex_r;
  logic [WP_BITS-1:0]  wpc_r [RB];
  logic [mrsi_pkg::REG_IDX_W-1:0] reg_idx;
  logic [1:0]          wp_sel;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[mrsi_pkg::ADDR_W-1:2];
  assign wp_sel  = 2'(reg_idx - mrsi_pkg::REG_WP0);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_r <= POS_BITS'(1);
      for (int i = 0; i < RB; i++) wpc_r[i] <= WP_BITS'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        mrsi_pkg::REG_VERTEX: vertex_r <= pwdata[POS_BITS-1:0];
        mrsi_pkg::REG_WP0, mrsi_pkg::REG_WP1,
        mrsi_pkg::REG_WP2, mrsi_pkg::REG_WP3: wpc_r[wp_sel] <= pwdata[WP_BITS-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mrsi_pkg::REG_VERTEX: prdata = 32'(vertex_r);
      mrsi_pkg::REG_WP0, mrsi_pkg::REG_WP1,
      mrsi_pkg::REG_WP2, mrsi_pkg::REG_WP3: prdata = 32'(wpc_r[wp_sel]);
      default: prdata = '0;
    endcase
  end

  // radix of each digit slot, zero taken as one
  logic [DW-1:0] slot_radix [ND];
  for (genvar s = 0; s < ND; s++) begin : g_radix
    if (s < RB) begin : g_pos
      assign slot_radix[s] = (vertex_r == '0) ? DW'(1) : DW'(vertex_r);
    end else begin : g_wp
      assign slot_radix[s] = (wpc_r[s-RB] == '0) ? DW'(1) : DW'(wpc_r[s-RB]);
    end
  end

  // chain input
  mrsi_pkg::ctl_t ctl_c [ND+1];
  logic [AW-1:0]  acc_c [ND+1];
  logic [GW-1:0]  dig_c [ND+1];

  always_comb begin
    ctl_c[0].valid = start & ~busy;
    ctl_c[0].func  = in_func;
    ctl_c[0].ovf   = 1'b0;
    acc_c[0]       = (in_func == mrsi_pkg::FUNC_DECODE) ? in_state_index : '0;
    dig_c[0]       = '0;
    if (in_func == mrsi_pkg::FUNC_ENCODE) begin
      dig_c[0][0*DW +: DW]      = DW'(in_pos_in_0);
      dig_c[0][1*DW +: DW]      = DW'(in_pos_in_1);
      dig_c[0][2*DW +: DW]      = DW'(in_pos_in_2);
      dig_c[0][3*DW +: DW]      = DW'(in_pos_in_3);
      dig_c[0][(RB+0)*DW +: DW] = DW'(in_wp_in_0);
      dig_c[0][(RB+1)*DW +: DW] = DW'(in_wp_in_1);
      dig_c[0][(RB+2)*DW +: DW] = DW'(in_wp_in_2);
      dig_c[0][(RB+3)*DW +: DW] = DW'(in_wp_in_3);
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_cell
    mrsi_cell #(
      .DW       (DW),
      .ENC_SLOT (k),
      .DEC_SLOT (ND - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .radix_enc (slot_radix[k]),
      .radix_dec (slot_radix[ND-1-k]),
      .ctl_in    (ctl_c[k]),
      .acc_in    (acc_c[k]),
      .dig_in    (dig_c[k]),
      .ctl_out   (ctl_c[k+1]),
      .acc_out   (acc_c[k+1]),
      .dig_out   (dig_c[k+1])
    );
  end

  // result register
  logic          valid_r;
  logic [AW-1:0] index_r;
  logic          ovf_r;
  logic [GW-1:0] dig_r;
  logic          is_dec;

  assign is_dec = (ctl_c[ND].func == mrsi_pkg::FUNC_DECODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_c[ND].valid;
    end
    index_r <= is_dec ? '0 : acc_c[ND];
    ovf_r   <= is_dec ? 1'b0 : ctl_c[ND].ovf;
    dig_r   <= is_dec ? dig_c[ND] : '0;
  end

  assign out_valid     = valid_r;
  assign out_index_out = index_r;
  assign out_overflow  = ovf_r;
  assign out_pos_out_0 = dig_r[0*DW +: POS_BITS];
  assign out_pos_out_1 = dig_r[1*DW +: POS_BITS];
  assign out_pos_out_2 = dig_r[2*DW +: POS_BITS];
  assign out_pos_out_3 = dig_r[3*DW +: POS_BITS];
  assign out_wp_out_0  = dig_r[(RB+0)*DW +: WP_BITS];
  assign out_wp_out_1  = dig_r[(RB+1)*DW +: WP_BITS];
  assign out_wp_out_2  = dig_r[(RB+2)*DW +: WP_BITS];
  assign out_wp_out_3  = dig_r[(RB+3)*DW +: WP_BITS];

`ifndef SYNTHESIS
  a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid) else $error("result missing after fixed latency");

  a_latency_none: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##LAT !out_valid) else $error("result without transaction");

  a_enc_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_overflow |-> (out_pos_out_0 == '0 && out_wp_out_3 == '0))
    else $error("encode result carries decoded digits");

  a_dec_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pos_out_0 != '0 || out_wp_out_0 != '0) |-> out_index_out == '0)
    else $error("decode result carries an index");
`endif

endmodule
